[hdl/assert_macros.svh]
// Assertion shorthands used by the checker file.
// Both expect signals named clk and rst in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/ufp_pkg.sv]
`timescale 1ns / 1ps

package ufp_pkg;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Register indexes, at byte address 4 * index.
  localparam logic [1:0] REG_PAYLOAD_LIMIT = 2'd0;
  localparam logic [1:0] REG_SYNC_FIRST    = 2'd1;
  localparam logic [1:0] REG_SYNC_SECOND   = 2'd2;

  localparam logic [15:0] PAYLOAD_LIMIT_RST = 16'd1024;
  localparam logic [7:0]  SYNC_FIRST_RST    = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND_RST   = 8'h62;

  // Result status codes.
  localparam logic [1:0] ST_BUSY    = 2'd0;
  localparam logic [1:0] ST_OK      = 2'd1;
  localparam logic [1:0] ST_LEN_ERR = 2'd2;
  localparam logic [1:0] ST_CK_ERR  = 2'd3;

  typedef enum logic [8:0] {
    PH_SYNC1   = 9'b000000001,
    PH_SYNC2   = 9'b000000010,
    PH_CLASS   = 9'b000000100,
    PH_IDENT   = 9'b000001000,
    PH_LENLO   = 9'b000010000,
    PH_LENHI   = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_CHECKA  = 9'b010000000,
    PH_CHECKB  = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [15:0] payload_limit;
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
  } ufp_cfg_t;

  // Statistics events raised by one item.
  typedef struct packed {
    logic       frame_ok;
    logic [1:0] hunt_inc;
    logic       len_err;
    logic       ck_err;
  } ufp_evt_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  msg_class;
    logic [7:0]  msg_ident;
    logic [15:0] payload_length;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
  } ufp_result_t;

endpackage

[hdl/ubx_frame_parser_unit.sv]
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// input     in_valid / in_ready  rx_byte
// output    out_valid/out_ready  status, msg_class, msg_ident, payload_length,
//                                payload_valid, payload_byte, payload_index,
//                                frame_count, hunt_count, length_error_count,
//                                checksum_error_count
// config    APB, pready high     payload_limit @0x0, sync_first @0x4, sync_second @0x8
//
// One item per clock cycle unless the output stalls; each accepted item's result
// reaches the output register in the next cycle, together with the parse state update.
// Reset is synchronous and returns the parser, counters and registers to defaults.
// A new item is taken whenever the output register is empty or being emptied.

module ubx_frame_parser_unit
  import ufp_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [7:0]         msg_class,
  output logic [7:0]         msg_ident,
  output logic [15:0]        payload_length,
  output logic               payload_valid,
  output logic [7:0]         payload_byte,
  output logic [15:0]        payload_index,
  output logic [31:0]        frame_count,
  output logic [31:0]        hunt_count,
  output logic [31:0]        length_error_count,
  output logic [31:0]        checksum_error_count,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  ufp_cfg_t    cfg;
  ufp_evt_t    evt;
  ufp_result_t result_next;
  ufp_result_t result;
  logic        accept;

  logic [COUNTER_WIDTH-1:0] frame_cnt;
  logic [COUNTER_WIDTH-1:0] hunt_cnt;
  logic [COUNTER_WIDTH-1:0] len_err_cnt;
  logic [COUNTER_WIDTH-1:0] ck_err_cnt;

  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;

  ufp_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ufp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .en      (accept),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .result  (result_next),
    .evt     (evt)
  );

  ufp_stats #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_stats (
    .clk         (clk),
    .rst         (rst),
    .en          (accept),
    .evt         (evt),
    .frame_cnt   (frame_cnt),
    .hunt_cnt    (hunt_cnt),
    .len_err_cnt (len_err_cnt),
    .ck_err_cnt  (ck_err_cnt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign status         = result.status;
  assign msg_class      = result.msg_class;
  assign msg_ident      = result.msg_ident;
  assign payload_length = result.payload_length;
  assign payload_valid  = result.payload_valid;
  assign payload_byte   = result.payload_byte;
  assign payload_index  = result.payload_index;

  // Counters move only on accept, i.e. when the output is empty or the shown result
  // leaves, so they can be presented straight from their registers.
  assign frame_count          = 32'(frame_cnt);
  assign hunt_count           = 32'(hunt_cnt);
  assign length_error_count   = 32'(len_err_cnt);
  assign checksum_error_count = 32'(ck_err_cnt);

endmodule

[hdl/ufp_cfg_regs.sv]
`timescale 1ns / 1ps

module ufp_cfg_regs
  import ufp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output ufp_cfg_t           cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.payload_limit <= PAYLOAD_LIMIT_RST;
      cfg.sync_first    <= SYNC_FIRST_RST;
      cfg.sync_second   <= SYNC_SECOND_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PAYLOAD_LIMIT: cfg.payload_limit <= pwdata[15:0];
        REG_SYNC_FIRST:    cfg.sync_first    <= pwdata[7:0];
        REG_SYNC_SECOND:   cfg.sync_second   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PAYLOAD_LIMIT: prdata = {16'd0, cfg.payload_limit};
      REG_SYNC_FIRST:    prdata = {24'd0, cfg.sync_first};
      REG_SYNC_SECOND:   prdata = {24'd0, cfg.sync_second};
      default:           prdata = '0;
    endcase
  end

endmodule

[hdl/ufp_parser.sv]
`timescale 1ns / 1ps

module ufp_parser
  import ufp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [7:0]  rx_byte,
  input  ufp_cfg_t    cfg,
  output ufp_result_t result,
  output ufp_evt_t    evt
);

  phase_t      phase;
  logic [7:0]  frame_class;
  logic [7:0]  frame_ident;
  logic [15:0] frame_length;
  logic [15:0] byte_position;
  logic [7:0]  sum_low;
  logic [7:0]  sum_high;
  logic [7:0]  check_low;
  logic        frame_done;

  phase_t      phase_next;
  logic [7:0]  frame_class_next;
  logic [7:0]  frame_ident_next;
  logic [15:0] frame_length_next;
  logic [15:0] byte_position_next;
  logic [7:0]  sum_low_next;
  logic [7:0]  sum_high_next;
  logic [7:0]  check_low_next;
  logic        frame_done_next;

  phase_t      cur_phase;
  logic [7:0]  cur_class;
  logic [7:0]  cur_ident;
  logic [15:0] cur_length;
  logic [15:0] cur_position;
  logic [7:0]  cur_sum_low;
  logic [7:0]  cur_sum_high;
  logic [7:0]  cur_check_low;

  logic [7:0]  sum_low_add;
  logic [7:0]  sum_high_add;
  logic [15:0] length_full;
  logic [15:0] position_inc;
  logic        retry;
  logic        hunt_first;
  logic        hunt_retry;
  logic [1:0]  status;
  logic        pvalid;

  // A completed frame is wiped before the next byte is looked at.
  always_comb begin
    if (frame_done) begin
      cur_phase     = PH_SYNC1;
      cur_class     = '0;
      cur_ident     = '0;
      cur_length    = '0;
      cur_position  = '0;
      cur_sum_low   = '0;
      cur_sum_high  = '0;
      cur_check_low = '0;
    end else begin
      cur_phase     = phase;
      cur_class     = frame_class;
      cur_ident     = frame_ident;
      cur_length    = frame_length;
      cur_position  = byte_position;
      cur_sum_low   = sum_low;
      cur_sum_high  = sum_high;
      cur_check_low = check_low;
    end
  end

  assign sum_low_add  = cur_sum_low + rx_byte;
  assign sum_high_add = cur_sum_high + sum_low_add;
  assign length_full  = {rx_byte, cur_length[7:0]};
  assign position_inc = cur_position + 16'd1;

  always_comb begin
    phase_next         = cur_phase;
    frame_class_next   = cur_class;
    frame_ident_next   = cur_ident;
    frame_length_next  = cur_length;
    byte_position_next = cur_position;
    sum_low_next       = cur_sum_low;
    sum_high_next      = cur_sum_high;
    check_low_next     = cur_check_low;
    frame_done_next    = 1'b0;
    retry              = 1'b0;
    hunt_first         = 1'b0;
    hunt_retry         = 1'b0;
    status             = ST_BUSY;
    pvalid             = 1'b0;
    evt                = '0;

    case (cur_phase)
      PH_SYNC1: begin
        if (rx_byte == cfg.sync_first) begin
          phase_next = PH_SYNC2;
        end else begin
          hunt_first = 1'b1;
        end
      end
      PH_SYNC2: begin
        if (rx_byte == cfg.sync_second) begin
          sum_low_next  = '0;
          sum_high_next = '0;
          phase_next    = PH_CLASS;
        end else begin
          hunt_first = 1'b1;
          retry      = 1'b1;
        end
      end
      PH_CLASS: begin
        frame_class_next = rx_byte;
        sum_low_next     = sum_low_add;
        sum_high_next    = sum_high_add;
        phase_next       = PH_IDENT;
      end
      PH_IDENT: begin
        frame_ident_next = rx_byte;
        sum_low_next     = sum_low_add;
        sum_high_next    = sum_high_add;
        phase_next       = PH_LENLO;
      end
      PH_LENLO: begin
        frame_length_next = {8'd0, rx_byte};
        sum_low_next      = sum_low_add;
        sum_high_next     = sum_high_add;
        phase_next        = PH_LENHI;
      end
      PH_LENHI: begin
        frame_length_next = length_full;
        sum_low_next      = sum_low_add;
        sum_high_next     = sum_high_add;
        if (length_full > cfg.payload_limit) begin
          evt.len_err = 1'b1;
          status      = ST_LEN_ERR;
          retry       = 1'b1;
        end else begin
          byte_position_next = '0;
          phase_next = (length_full == 16'd0) ? PH_CHECKA : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        pvalid             = 1'b1;
        byte_position_next = position_inc;
        sum_low_next       = sum_low_add;
        sum_high_next      = sum_high_add;
        if (position_inc >= cur_length) begin
          phase_next = PH_CHECKA;
        end
      end
      PH_CHECKA: begin
        check_low_next = rx_byte;
        phase_next     = PH_CHECKB;
      end
      default: begin
        if (cur_check_low == cur_sum_low && rx_byte == cur_sum_high) begin
          frame_done_next = 1'b1;
          evt.frame_ok    = 1'b1;
          status          = ST_OK;
        end else begin
          evt.ck_err = 1'b1;
          status     = ST_CK_ERR;
          retry      = 1'b1;
        end
      end
    endcase

    // The byte that broke the frame gets one more look as a first sync byte.
    if (retry) begin
      if (rx_byte == cfg.sync_first) begin
        phase_next = PH_SYNC2;
      end else begin
        phase_next = PH_SYNC1;
        hunt_retry = 1'b1;
      end
    end

    evt.hunt_inc = {1'b0, hunt_first} + {1'b0, hunt_retry};
  end

  always_comb begin
    result.status         = status;
    result.msg_class      = (status == ST_OK) ? frame_class_next : '0;
    result.msg_ident      = (status == ST_OK) ? frame_ident_next : '0;
    result.payload_length = (status == ST_OK) ? frame_length_next : '0;
    result.payload_valid  = pvalid;
    result.payload_byte   = pvalid ? rx_byte : '0;
    result.payload_index  = pvalid ? cur_position : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SYNC1;
      frame_class   <= '0;
      frame_ident   <= '0;
      frame_length  <= '0;
      byte_position <= '0;
      sum_low       <= '0;
      sum_high      <= '0;
      check_low     <= '0;
      frame_done    <= 1'b0;
    end else if (en) begin
      phase         <= phase_next;
      frame_class   <= frame_class_next;
      frame_ident   <= frame_ident_next;
      frame_length  <= frame_length_next;
      byte_position <= byte_position_next;
      sum_low       <= sum_low_next;
      sum_high      <= sum_high_next;
      check_low     <= check_low_next;
      frame_done    <= frame_done_next;
    end
  end

endmodule

[hdl/ufp_stats.sv]
`timescale 1ns / 1ps

module ufp_stats
  import ufp_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  ufp_evt_t                 evt,
  output logic [COUNTER_WIDTH-1:0] frame_cnt,
  output logic [COUNTER_WIDTH-1:0] hunt_cnt,
  output logic [COUNTER_WIDTH-1:0] len_err_cnt,
  output logic [COUNTER_WIDTH-1:0] ck_err_cnt
);

  // All counters wrap naturally at their width.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cnt   <= '0;
      hunt_cnt    <= '0;
      len_err_cnt <= '0;
      ck_err_cnt  <= '0;
    end else if (en) begin
      frame_cnt   <= frame_cnt + COUNTER_WIDTH'(evt.frame_ok);
      hunt_cnt    <= hunt_cnt + COUNTER_WIDTH'(evt.hunt_inc);
      len_err_cnt <= len_err_cnt + COUNTER_WIDTH'(evt.len_err);
      ck_err_cnt  <= ck_err_cnt + COUNTER_WIDTH'(evt.ck_err);
    end
  end

endmodule

[hdl/ufp_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ufp_checker
  import ufp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [7:0]  msg_class,
  input logic [7:0]  msg_ident,
  input logic [15:0] payload_length,
  input logic        payload_valid,
  input logic [7:0]  payload_byte,
  input logic [15:0] payload_index
);

  `ASSERT_CLK(a_ready_when_empty, !out_valid |-> in_ready, "block not ready while output empty")

  `ASSERT_CLK(a_drain, out_valid && out_ready && !in_valid |=> !out_valid, "result shown twice")

  `ASSERT_CLK(a_payload_busy, out_valid && payload_valid |-> status == ST_BUSY, "payload item with final status")

  `ASSERT_CLK(a_header_zero, out_valid && status != ST_OK |-> msg_class == 8'd0 && msg_ident == 8'd0 && payload_length == 16'd0, "header shown without complete frame")

  `ASSERT_CLK(a_payload_zero, out_valid && !payload_valid |-> payload_byte == 8'd0 && payload_index == 16'd0, "payload fields set on non-payload item")

endmodule

bind ubx_frame_parser_unit ufp_checker u_checker (.*);

[dv/ubx_frame_parser_unit_tb.sv]
`timescale 1ns / 1ps

module ubx_frame_parser_unit_tb;
  import ufp_pkg::*;

  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 260;
  localparam int unsigned HOLD_CYCLES = 300;

  // Full observation of one result: the frame fields plus the four counters.
  typedef struct packed {
    ufp_result_t res;
    logic [31:0] frames;
    logic [31:0] hunt;
    logic [31:0] len_err;
    logic [31:0] ck_err;
  } parse_obs_t;

  // One row of the directed table. Where typed is set, status and counters are
  // taken from the row instead of the predictor.
  typedef struct packed {
    logic [7:0]  b;
    logic        typed;
    logic [1:0]  st;
    logic [31:0] frames;
    logic [31:0] hunt;
    logic [31:0] len_err;
    logic [31:0] ck_err;
  } row_t;

  localparam int unsigned N_ROWS = 28;
  localparam row_t DIRECTED [N_ROWS] = '{
    '{8'h00, 1'b1, ST_BUSY, 0, 1, 0, 0},     // extremes while hunting
    '{8'hFF, 1'b1, ST_BUSY, 0, 2, 0, 0},
    '{8'hB5, 1'b0, ST_BUSY, 0, 0, 0, 0},
    '{8'h00, 1'b1, ST_BUSY, 0, 4, 0, 0},     // second-sync miss counts twice
    '{8'hB5, 1'b0, ST_BUSY, 0, 0, 0, 0},
    '{8'hB5, 1'b0, ST_BUSY, 0, 0, 0, 0},     // miss, retried as first sync
    '{8'h62, 1'b0, ST_BUSY, 0, 0, 0, 0},
    '{8'h01, 1'b0, ST_BUSY, 0, 0, 0, 0},
    '{8'h02, 1'b0, ST_BUSY, 0, 0, 0, 0},
    '{8'h00, 1'b0, ST_BUSY, 0, 0, 0, 0},
    '{8'h00, 1'b0, ST_BUSY, 0, 0, 0, 0},     // zero length
    '{8'h03, 1'b0, ST_BUSY, 0, 0, 0, 0},
    '{8'h0A, 1'b1, ST_OK,   1, 5, 0, 0},
    '{8'hB5, 1'b0, ST_BUSY, 0, 0, 0, 0},     // first byte after a good frame
    '{8'h62, 1'b0, ST_BUSY, 0, 0, 0, 0},
    '{8'hFF, 1'b0, ST_BUSY, 0, 0, 0, 0},
    '{8'hFF, 1'b0, ST_BUSY, 0, 0, 0, 0},
    '{8'hFF, 1'b0, ST_BUSY, 0, 0, 0, 0},
    '{8'hFF, 1'b1, ST_LEN_ERR, 1, 6, 1, 0},  // largest length, over the limit
    '{8'hB5, 1'b0, ST_BUSY, 0, 0, 0, 0},
    '{8'h62, 1'b0, ST_BUSY, 0, 0, 0, 0},
    '{8'h10, 1'b0, ST_BUSY, 0, 0, 0, 0},
    '{8'h20, 1'b0, ST_BUSY, 0, 0, 0, 0},
    '{8'h01, 1'b0, ST_BUSY, 0, 0, 0, 0},
    '{8'h00, 1'b0, ST_BUSY, 0, 0, 0, 0},
    '{8'hAB, 1'b0, ST_BUSY, 0, 0, 0, 0},
    '{8'h00, 1'b0, ST_BUSY, 0, 0, 0, 0},
    '{8'hB5, 1'b1, ST_CK_ERR, 1, 6, 1, 1}    // bad check, retried as sync
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic [7:0]         msg_class;
  logic [7:0]         msg_ident;
  logic [15:0]        payload_length;
  logic               payload_valid;
  logic [7:0]         payload_byte;
  logic [15:0]        payload_index;
  logic [31:0]        frame_count;
  logic [31:0]        hunt_count;
  logic [31:0]        length_error_count;
  logic [31:0]        checksum_error_count;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  row_t cur_row = '0;

  // Shadow copy of the registers.
  logic [15:0] cfg_limit = PAYLOAD_LIMIT_RST;
  logic [7:0]  cfg_sync1 = SYNC_FIRST_RST;
  logic [7:0]  cfg_sync2 = SYNC_SECOND_RST;

  // Shadow copy of the parser state.
  phase_t      p_phase = PH_SYNC1;
  logic [7:0]  p_class = '0;
  logic [7:0]  p_ident = '0;
  logic [15:0] p_length = '0;
  logic [15:0] p_pos = '0;
  logic [7:0]  p_lo = '0;
  logic [7:0]  p_hi = '0;
  logic [7:0]  p_check_lo = '0;
  logic        p_done = 1'b0;
  logic [31:0] n_frames = '0;
  logic [31:0] n_hunt = '0;
  logic [31:0] n_len_err = '0;
  logic [31:0] n_ck_err = '0;

  parse_obs_t  pending_results[$];
  logic [7:0]  byte_stream[$];
  int unsigned fault_count = 0;
  int unsigned stuck_cycles = 0;
  int unsigned stall_left = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  ubx_frame_parser_unit dut (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .rx_byte              (rx_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .status               (status),
    .msg_class            (msg_class),
    .msg_ident            (msg_ident),
    .payload_length       (payload_length),
    .payload_valid        (payload_valid),
    .payload_byte         (payload_byte),
    .payload_index        (payload_index),
    .frame_count          (frame_count),
    .hunt_count           (hunt_count),
    .length_error_count   (length_error_count),
    .checksum_error_count (checksum_error_count),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always #5 clk = ~clk;

  task automatic note_fault(input string msg);
    if (fault_count < 10) $display("%s", msg);
    fault_count++;
  endtask

  function automatic string obs_text(input parse_obs_t o);
    return $sformatf("st=%0d cls=%h id=%h len=%0d pv=%b pb=%h pi=%0d cnt=%0d/%0d/%0d/%0d",
                     o.res.status, o.res.msg_class, o.res.msg_ident, o.res.payload_length,
                     o.res.payload_valid, o.res.payload_byte, o.res.payload_index,
                     o.frames, o.hunt, o.len_err, o.ck_err);
  endfunction

  // Fletcher-8 running sum step.
  task automatic fletcher_add(inout logic [7:0] lo, inout logic [7:0] hi, input logic [7:0] b);
    lo = lo + b;
    hi = hi + lo;
  endtask

  task automatic parse_byte(input logic [7:0] b, output parse_obs_t o);
    logic [1:0]  st;
    logic        pv;
    logic [7:0]  pb;
    logic [15:0] pi;
    bit          retry;
    int          pass;
    st = ST_BUSY;
    pv = 1'b0;
    pb = '0;
    pi = '0;
    // A completed frame is cleared by the next byte; the counters survive.
    if (p_done) begin
      p_phase = PH_SYNC1;
      p_class = '0;
      p_ident = '0;
      p_length = '0;
      p_pos = '0;
      p_lo = '0;
      p_hi = '0;
      p_check_lo = '0;
      p_done = 1'b0;
    end
    for (pass = 0; pass < 2; pass++) begin
      retry = 1'b0;
      case (p_phase)
        PH_SYNC1: begin
          if (b == cfg_sync1) p_phase = PH_SYNC2;
          else n_hunt = n_hunt + 1;
        end
        PH_SYNC2: begin
          if (b == cfg_sync2) begin
            p_lo = '0;
            p_hi = '0;
            p_phase = PH_CLASS;
          end else begin
            n_hunt = n_hunt + 1;
            p_phase = PH_SYNC1;
            retry = 1'b1;
          end
        end
        PH_CLASS: begin
          p_class = b;
          fletcher_add(p_lo, p_hi, b);
          p_phase = PH_IDENT;
        end
        PH_IDENT: begin
          p_ident = b;
          fletcher_add(p_lo, p_hi, b);
          p_phase = PH_LENLO;
        end
        PH_LENLO: begin
          p_length = {8'h00, b};
          fletcher_add(p_lo, p_hi, b);
          p_phase = PH_LENHI;
        end
        PH_LENHI: begin
          p_length = {b, p_length[7:0]};
          fletcher_add(p_lo, p_hi, b);
          if (p_length > cfg_limit) begin
            n_len_err = n_len_err + 1;
            p_phase = PH_SYNC1;
            st = ST_LEN_ERR;
            retry = 1'b1;
          end else begin
            p_pos = '0;
            p_phase = (p_length == 0) ? PH_CHECKA : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          pv = 1'b1;
          pb = b;
          pi = p_pos;
          p_pos = p_pos + 16'd1;
          fletcher_add(p_lo, p_hi, b);
          if (p_pos >= p_length) p_phase = PH_CHECKA;
        end
        PH_CHECKA: begin
          p_check_lo = b;
          p_phase = PH_CHECKB;
        end
        default: begin
          if (p_check_lo == p_lo && b == p_hi) begin
            p_done = 1'b1;
            n_frames = n_frames + 1;
            st = ST_OK;
          end else begin
            n_ck_err = n_ck_err + 1;
            p_phase = PH_SYNC1;
            st = ST_CK_ERR;
            retry = 1'b1;
          end
        end
      endcase
      if (!retry) break;
    end
    o.res.status = st;
    o.res.msg_class = (st == ST_OK) ? p_class : 8'h00;
    o.res.msg_ident = (st == ST_OK) ? p_ident : 8'h00;
    o.res.payload_length = (st == ST_OK) ? p_length : 16'h0000;
    o.res.payload_valid = pv;
    o.res.payload_byte = pb;
    o.res.payload_index = pi;
    o.frames = n_frames;
    o.hunt = n_hunt;
    o.len_err = n_len_err;
    o.ck_err = n_ck_err;
  endtask

  // Every accepted item gets its expected result queued here.
  always @(posedge clk) begin : watch_in
    parse_obs_t e;
    if (!rst && in_valid && in_ready) begin
      parse_byte(rx_byte, e);
      if (cur_row.typed) begin
        e.res.status = cur_row.st;
        e.frames = cur_row.frames;
        e.hunt = cur_row.hunt;
        e.len_err = cur_row.len_err;
        e.ck_err = cur_row.ck_err;
      end
      pending_results.push_back(e);
    end
  end

  always @(posedge clk) begin : watch_out
    parse_obs_t got;
    parse_obs_t want;
    if (!rst && out_valid && out_ready) begin
      got.res.status = status;
      got.res.msg_class = msg_class;
      got.res.msg_ident = msg_ident;
      got.res.payload_length = payload_length;
      got.res.payload_valid = payload_valid;
      got.res.payload_byte = payload_byte;
      got.res.payload_index = payload_index;
      got.frames = frame_count;
      got.hunt = hunt_count;
      got.len_err = length_error_count;
      got.ck_err = checksum_error_count;
      if (pending_results.size() == 0) begin
        note_fault($sformatf("unexpected result: %s", obs_text(got)));
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          note_fault($sformatf("mismatch\n  expected %s\n  actual   %s",
                               obs_text(want), obs_text(got)));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Receiver: short random stalls, one long hold when asked, none at the end.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 7);
      end
      out_ready <= (stall_left == 0);
    end
  end

  task automatic send_item(input logic [7:0] b, input row_t r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    cur_row <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  // Lowers valid and waits until every queued result has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val,
                           input logic [31:0] mask);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // Read the register straight back.
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if ((got & mask) !== (val & mask))
      note_fault($sformatf("register %0d read back %h, wrote %h", idx, got, val));
  endtask

  // Appends one piece of stream: mostly whole frames with random content,
  // the rest broken frames and line noise.
  task automatic build_piece();
    int unsigned kind;
    int unsigned cap;
    int unsigned k;
    logic [15:0] len;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  cls;
    logic [7:0]  idt;
    logic [7:0]  pb;
    bit          too_long;
    kind = $urandom_range(0, 99);
    if (kind >= 86) begin
      repeat ($urandom_range(1, 6)) byte_stream.push_back(8'($urandom_range(0, 255)));
    end else if (kind >= 78) begin
      byte_stream.push_back(cfg_sync1);
      byte_stream.push_back(cfg_sync2 ^ 8'($urandom_range(1, 255)));
    end else begin
      cls = 8'($urandom_range(0, 255));
      idt = 8'($urandom_range(0, 255));
      too_long = (kind >= 70) && (cfg_limit != 16'hFFFF);
      if (too_long) begin
        len = 16'(cfg_limit + 1 + $urandom_range(0, 65534 - cfg_limit));
      end else begin
        cap = (cfg_limit < 8) ? cfg_limit : 8;
        if ($urandom_range(0, 29) == 0) cap = (cfg_limit < 300) ? cfg_limit : 300;
        len = 16'($urandom_range(0, cap));
      end
      lo = '0;
      hi = '0;
      byte_stream.push_back(cfg_sync1);
      byte_stream.push_back(cfg_sync2);
      byte_stream.push_back(cls);
      byte_stream.push_back(idt);
      byte_stream.push_back(len[7:0]);
      byte_stream.push_back(len[15:8]);
      if (!too_long) begin
        fletcher_add(lo, hi, cls);
        fletcher_add(lo, hi, idt);
        fletcher_add(lo, hi, len[7:0]);
        fletcher_add(lo, hi, len[15:8]);
        for (k = 0; k < len; k++) begin
          pb = 8'($urandom_range(0, 255));
          byte_stream.push_back(pb);
          fletcher_add(lo, hi, pb);
        end
        if (kind >= 60) begin
          if ($urandom_range(0, 1) == 0) lo = lo ^ 8'($urandom_range(1, 255));
          else hi = hi ^ 8'($urandom_range(1, 255));
        end
        byte_stream.push_back(lo);
        byte_stream.push_back(hi);
      end
    end
  endtask

  initial begin : main
    int unsigned i;
    int unsigned ph;
    int unsigned sent;
    logic [15:0] lim;
    logic [7:0]  s1;
    logic [7:0]  s2;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < N_ROWS; i++) send_item(DIRECTED[i].b, DIRECTED[i]);

    for (ph = 1; ph <= 5; ph++) begin
      drain();
      case (ph)
        1: begin lim = 16'd1024; s1 = 8'hB5; s2 = 8'h62; end
        2: begin lim = 16'd0;    s1 = 8'h00; s2 = 8'hFF; end
        3: begin lim = 16'hFFFF; s1 = 8'hFF; s2 = 8'h00; end
        4: begin
          lim = 16'($urandom_range(1, 64));
          s1 = 8'($urandom_range(0, 255));
          s2 = 8'($urandom_range(0, 255));
        end
        default: begin lim = 16'd1; s1 = 8'hB5; s2 = 8'h62; end
      endcase
      reg_write(REG_PAYLOAD_LIMIT, {16'h0000, lim}, 32'h0000FFFF);
      reg_write(REG_SYNC_FIRST, {24'h000000, s1}, 32'h000000FF);
      reg_write(REG_SYNC_SECOND, {24'h000000, s2}, 32'h000000FF);
      cfg_limit = lim;
      cfg_sync1 = s1;
      cfg_sync2 = s2;
      // The receiver holds off for a long stretch early on so the input backs up.
      if (ph == 1) hold_req = 1'b1;
      if (ph == 5) calm = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_piece();
        while (byte_stream.size() != 0) begin
          send_item(byte_stream.pop_front(), '0);
          sent++;
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/ufp_pkg.sv
hdl/ufp_cfg_regs.sv
hdl/ufp_parser.sv
hdl/ufp_stats.sv
hdl/ubx_frame_parser_unit.sv
hdl/ufp_checker.sv
dv/ubx_frame_parser_unit_tb.sv
